>>> sv/kntab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kntab_pkg
// Shared types and codes of the keyed node table.
// ----------------------------------------------------------------------------
package kntab_pkg;

	localparam int KEY_W     = 48;
	localparam int LAYER_W   = 6;
	localparam int VER_W     = 64;
	localparam int MODE_W    = 2;
	localparam int STATUS_W  = 3;
	localparam int COUNT_O_W = 7;
	localparam int INDEX_O_W = 6;

	localparam logic [MODE_W-1:0] MODE_UPSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_UNCHANGED = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND  = 3'd5;
	localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd6;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [KEY_W-1:0]   parent;
		logic [LAYER_W-1:0] layer;
		logic [VER_W-1:0]   version;
	} entry_t;

	// flags carried by the search wave from cell to cell
	typedef struct packed {
		logic removed;
		logic found;
		logic differs;
	} flags_t;

endpackage

>>> sv/keyed_node_table_upsert_remove_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_node_table_upsert_remove_core
// Ordered node table keyed by address: upsert, remove with compaction, clear.
//
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  mode, node_addr, parent_addr,
//                                          node_layer, version_word
// out      output     out_valid / out_stall status, entry_count, entry_index
//
// for each word, a search wave walks the row of cells one slot per cycle,
// then the finish step applies the write and the new count.
// reset empties the table; entry contents are not cleared.
// a finished result sits in the output register, so the next word is taken
// while it waits; a stalled result holds the table in its finish step.
// ----------------------------------------------------------------------------
module keyed_node_table_upsert_remove_core #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [kntab_pkg::MODE_W-1:0]         mode,
	input  logic [kntab_pkg::KEY_W-1:0]          node_addr,
	input  logic [kntab_pkg::KEY_W-1:0]          parent_addr,
	input  logic [kntab_pkg::LAYER_W-1:0]        node_layer,
	input  logic [kntab_pkg::VER_W-1:0]          version_word,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [kntab_pkg::STATUS_W-1:0]       status,
	output logic [kntab_pkg::COUNT_O_W-1:0]      entry_count,
	output logic [kntab_pkg::INDEX_O_W-1:0]      entry_index
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SWEEP  = 2'd1;
	localparam logic [1:0] S_FINISH = 2'd2;

	logic [1:0]                       state_q;
	logic                             start_q;
	logic [kntab_pkg::MODE_W-1:0]     mode_q;
	kntab_pkg::entry_t                item_q;
	logic [CW-1:0]                    count_q;
	kntab_pkg::flags_t                fin_flags_q;
	logic [IW-1:0]                    fin_first_q;
	logic [IW-1:0]                    fin_slot_q;
	logic                             out_valid_q;
	logic [kntab_pkg::STATUS_W-1:0]   status_q;
	logic [kntab_pkg::COUNT_O_W-1:0]  count_out_q;
	logic [kntab_pkg::INDEX_O_W-1:0]  index_out_q;

	logic                             accept;
	logic                             finish_go;
	logic                             is_remove;
	logic [kntab_pkg::STATUS_W-1:0]   fin_status;
	logic [CW-1:0]                    fin_count;
	logic [IW-1:0]                    fin_idx;
	logic                             fin_wr;

	logic              tok   [TABLE_DEPTH:0];
	kntab_pkg::flags_t flags [TABLE_DEPTH:0];
	logic [IW-1:0]     first [TABLE_DEPTH:0];
	logic [IW-1:0]     slot  [TABLE_DEPTH:0];
	kntab_pkg::entry_t ents  [TABLE_DEPTH-1:0];

	assign in_stall  = state_q != S_IDLE;
	assign accept    = in_valid && !in_stall;
	assign finish_go = (state_q == S_FINISH) && (!out_valid_q || !out_stall);
	assign is_remove = mode_q == kntab_pkg::MODE_REMOVE;

	assign tok[0]   = start_q;
	assign flags[0] = '0;
	assign first[0] = '0;
	assign slot[0]  = '0;

	genvar gi;
	generate
		for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
			kntab_pkg::entry_t nb;
			if (gi == TABLE_DEPTH - 1) begin : g_last
				assign nb = ents[gi];
			end else begin : g_mid
				assign nb = ents[gi+1];
			end
			kntab_cell #(
				.IDX (gi),
				.IW  (IW),
				.CW  (CW)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.tok_in    (tok[gi]),
				.flags_in  (flags[gi]),
				.first_in  (first[gi]),
				.slot_in   (slot[gi]),
				.count     (count_q),
				.item      (item_q),
				.is_remove (is_remove),
				.wr_en     (finish_go && fin_wr),
				.wr_idx    (fin_idx),
				.next_ent  (nb),
				.tok_out   (tok[gi+1]),
				.flags_out (flags[gi+1]),
				.first_out (first[gi+1]),
				.slot_out  (slot[gi+1]),
				.ent       (ents[gi])
			);
		end
	endgenerate

	// outcome of the word once the wave has left the last cell
	always_comb begin
		fin_status = kntab_pkg::ST_UNCHANGED;
		fin_count  = count_q;
		fin_idx    = '0;
		fin_wr     = 1'b0;
		case (mode_q)
			kntab_pkg::MODE_UPSERT: begin
				if (fin_flags_q.found) begin
					if (fin_flags_q.differs) begin
						fin_status = kntab_pkg::ST_UPDATED;
						fin_idx    = fin_slot_q;
						fin_wr     = 1'b1;
					end
				end else if (count_q < CW'(TABLE_DEPTH)) begin
					fin_status = kntab_pkg::ST_ADDED;
					fin_idx    = IW'(count_q);
					fin_wr     = 1'b1;
					fin_count  = count_q + 1'b1;
				end else begin
					fin_status = kntab_pkg::ST_FULL;
				end
			end
			kntab_pkg::MODE_REMOVE: begin
				if (fin_flags_q.removed) begin
					fin_status = kntab_pkg::ST_REMOVED;
					fin_idx    = fin_first_q;
					fin_count  = count_q - 1'b1;
				end else begin
					fin_status = kntab_pkg::ST_NOTFOUND;
				end
			end
			kntab_pkg::MODE_CLEAR: begin
				fin_status = kntab_pkg::ST_CLEARED;
				fin_count  = '0;
			end
			default: begin
				fin_status = kntab_pkg::ST_UNCHANGED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			start_q     <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= accept;
			if (finish_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_SWEEP;
					end
				end
				S_SWEEP: begin
					if (tok[TABLE_DEPTH]) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (finish_go) begin
						state_q <= S_IDLE;
						count_q <= fin_count;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q         <= mode;
			item_q.key     <= node_addr;
			item_q.parent  <= parent_addr;
			item_q.layer   <= node_layer;
			item_q.version <= version_word;
		end
		if (tok[TABLE_DEPTH]) begin
			fin_flags_q <= flags[TABLE_DEPTH];
			fin_first_q <= first[TABLE_DEPTH];
			fin_slot_q  <= slot[TABLE_DEPTH];
		end
		if (finish_go) begin
			status_q    <= fin_status;
			count_out_q <= kntab_pkg::COUNT_O_W'(fin_count);
			index_out_q <= kntab_pkg::INDEX_O_W'(fin_idx);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_count = count_out_q;
	assign entry_index = index_out_q;

endmodule

>>> sv/kntab_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kntab_cell
// One table slot: holds an entry, compares it against the current word as the
// search wave passes, and takes its right neighbor's entry when compacting.
// ----------------------------------------------------------------------------
module kntab_cell #(
	parameter int IDX = 0,
	parameter int IW  = 6,
	parameter int CW  = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tok_in,
	input  kntab_pkg::flags_t flags_in,
	input  logic [IW-1:0]     first_in,
	input  logic [IW-1:0]     slot_in,
	input  logic [CW-1:0]     count,
	input  kntab_pkg::entry_t item,
	input  logic              is_remove,
	input  logic              wr_en,
	input  logic [IW-1:0]     wr_idx,
	input  kntab_pkg::entry_t next_ent,
	output logic              tok_out,
	output kntab_pkg::flags_t flags_out,
	output logic [IW-1:0]     first_out,
	output logic [IW-1:0]     slot_out,
	output kntab_pkg::entry_t ent
);

	kntab_pkg::entry_t ent_q;
	kntab_pkg::flags_t flags_d;
	kntab_pkg::flags_t flags_q;
	logic [IW-1:0]     first_d;
	logic [IW-1:0]     first_q;
	logic [IW-1:0]     slot_d;
	logic [IW-1:0]     slot_q;
	logic              tok_q;
	logic              in_use;
	logic              match;
	logic              diff;
	logic              shift;
	logic              wr_hit;

	assign in_use = CW'(IDX) < count;
	assign match  = in_use && (ent_q.key == item.key);
	assign diff   = (ent_q.parent != item.parent) || (ent_q.layer != item.layer) ||
		(ent_q.version != item.version);
	// an earlier or local match pulls the neighbor's entry down one slot
	assign shift  = tok_in && is_remove && in_use && (flags_in.removed || match);
	assign wr_hit = wr_en && (wr_idx == IW'(IDX));

	always_comb begin
		flags_d = flags_in;
		first_d = first_in;
		slot_d  = slot_in;
		flags_d.found   = flags_in.found | match;
		flags_d.removed = flags_in.removed | match;
		if (match && diff) begin
			flags_d.differs = 1'b1;
			slot_d          = IW'(IDX);
		end
		if (match && !flags_in.removed) begin
			first_d = IW'(IDX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q   <= 1'b0;
			flags_q <= '0;
		end else begin
			tok_q   <= tok_in;
			flags_q <= flags_d;
		end
	end

	always_ff @(posedge clk) begin
		first_q <= first_d;
		slot_q  <= slot_d;
		if (wr_hit) begin
			ent_q <= item;
		end else if (shift) begin
			ent_q <= next_ent;
		end
	end

	assign tok_out   = tok_q;
	assign flags_out = flags_q;
	assign first_out = first_q;
	assign slot_out  = slot_q;
	assign ent       = ent_q;

endmodule
